### hdl/tpb_pkg.sv
package tpb_pkg;

  localparam int unsigned CoordWidthDef     = 16;
  localparam int unsigned WeightFracBitsDef = 16;
  localparam int unsigned WeightWidth       = 20;
  localparam int unsigned QuoSteps          = WeightWidth - 1;
  localparam int unsigned CfgIdxWidth       = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic in_tri;
    logic cw;
    logic degen;
  } tpb_flags_t;

endpackage

### hdl/triangle_point_barycentric_test.sv
// Edge-function point-in-triangle test. Program the three vertices (signed
// fixed point, 4 fraction bits) through the config port while idle, then
// stream sample points. Each point yields inside/clockwise/degenerate flags
// and three barycentric weights (sub-area / area, signed, WEIGHT_FRAC_BITS
// fraction bits, truncated toward zero, saturated to 20 bits; zero when the
// triangle is degenerate). One point per cycle is sustained while the output
// is not stalled. Stages: subtract, multiply, edge, area, magnitude, then a
// 20-stage restoring divider (a saturation check, then one quotient bit per
// stage) and an output stage.
// Coordinates wider than 30 bits use only their low 30 bits.
module triangle_point_barycentric_test #(
  parameter int unsigned COORD_WIDTH      = tpb_pkg::CoordWidthDef,
  parameter int unsigned WEIGHT_FRAC_BITS = tpb_pkg::WeightFracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tpb_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]             cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [COORD_WIDTH-1:0]             point_x_i,
  input  logic [COORD_WIDTH-1:0]             point_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               inside_res_o,
  output logic                               clockwise_o,
  output logic                               degenerate_o,
  output logic [tpb_pkg::WeightWidth-1:0]    weight_a_o,
  output logic [tpb_pkg::WeightWidth-1:0]    weight_b_o,
  output logic [tpb_pkg::WeightWidth-1:0]    weight_c_o
);
  import tpb_pkg::*;

  localparam int unsigned CW       = (COORD_WIDTH > 30) ? 30 : COORD_WIDTH;
  localparam int unsigned DFW      = CW + 1;
  localparam int unsigned PW       = 2 * CW + 2;
  localparam int unsigned EW       = 2 * CW + 3;
  localparam int unsigned DivFirst = 5;
  localparam int unsigned OutSt    = DivFirst + QuoSteps + 1;
  localparam int unsigned NS       = OutSt + 1;

  // config registers
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; cx_q <= '0; cy_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_A_X: ax_q <= cfg_data_i[CW-1:0];
        REG_A_Y: ay_q <= cfg_data_i[CW-1:0];
        REG_B_X: bx_q <= cfg_data_i[CW-1:0];
        REG_B_Y: by_q <= cfg_data_i[CW-1:0];
        REG_C_X: cx_q <= cfg_data_i[CW-1:0];
        REG_C_Y: cy_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage moves when empty or when the next one moves
  logic [NS-1:0] v_q, en;

  assign en[NS-1] = !v_q[NS-1] || !out_stall_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: vertex minus point
  logic signed [CW-1:0]  px, py;
  logic signed [DFW-1:0] dax_q, day_q, dbx_q, dby_q, dcx_q, dcy_q;

  assign px = point_x_i[CW-1:0];
  assign py = point_y_i[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dax_q <= DFW'(ax_q) - DFW'(px);
      day_q <= DFW'(ay_q) - DFW'(py);
      dbx_q <= DFW'(bx_q) - DFW'(px);
      dby_q <= DFW'(by_q) - DFW'(py);
      dcx_q <= DFW'(cx_q) - DFW'(px);
      dcy_q <= DFW'(cy_q) - DFW'(py);
    end
  end

  // stage 1: cross-product terms
  logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m0_q <= dbx_q * dcy_q;
      m1_q <= dcx_q * dby_q;
      m2_q <= dcx_q * day_q;
      m3_q <= dax_q * dcy_q;
      m4_q <= dax_q * dby_q;
      m5_q <= dbx_q * day_q;
    end
  end

  // stage 2: sub-areas
  logic signed [EW-1:0] pbc_q, pca_q, pab_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pbc_q <= EW'(m0_q) - EW'(m1_q);
      pca_q <= EW'(m2_q) - EW'(m3_q);
      pab_q <= EW'(m4_q) - EW'(m5_q);
    end
  end

  // stage 3: area is the sum of the sub-areas; flags
  logic signed [EW-1:0] abc_q, wa_q, wb_q, wc_q;
  tpb_flags_t           flg_q [OutSt:3];
  logic                 has_neg, has_pos;
  tpb_flags_t           flg_d;

  always_comb begin
    has_neg = pbc_q[EW-1] || pca_q[EW-1] || pab_q[EW-1];
    has_pos = (!pbc_q[EW-1] && pbc_q != '0) || (!pca_q[EW-1] && pca_q != '0) ||
              (!pab_q[EW-1] && pab_q != '0);
    flg_d.in_tri = !(has_neg && has_pos);
    flg_d.cw     = flg_d.in_tri && !pab_q[EW-1] && pab_q != '0;
    flg_d.degen  = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      abc_q    <= pbc_q + pca_q + pab_q;
      wa_q     <= pbc_q;
      wb_q     <= pca_q;
      wc_q     <= pab_q;
      flg_q[3] <= flg_d;
    end
  end

  // stage 4: magnitudes and quotient signs
  logic [EW-1:0] den_q, na_q, nb_q, nc_q;
  logic          sa_q, sb_q, sc_q;

  function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] x);
    logic [EW-1:0] neg_x;
    neg_x = EW'(-x);
    return x[EW-1] ? neg_x : x;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      den_q    <= mag(abc_q);
      na_q     <= mag(wa_q);
      nb_q     <= mag(wb_q);
      nc_q     <= mag(wc_q);
      sa_q     <= wa_q[EW-1] ^ abc_q[EW-1];
      sb_q     <= wb_q[EW-1] ^ abc_q[EW-1];
      sc_q     <= wc_q[EW-1] ^ abc_q[EW-1];
      flg_q[4] <= '{in_tri: flg_q[3].in_tri, cw: flg_q[3].cw, degen: abc_q == '0};
    end
  end

  for (genvar k = 5; k <= OutSt; k++) begin : g_flg
    always_ff @(posedge clk_i) begin
      if (en[k]) flg_q[k] <= flg_q[k-1];
    end
  end

  // dividers
  logic [QuoSteps-1:0] qa, qb, qc;
  logic                sat_a, sat_b, sat_c, ng_a, ng_b, ng_c;

  tpb_divider #(.DW(EW), .FRAC(WEIGHT_FRAC_BITS)) u_div_a (
    .clk_i, .en_i(en[DivFirst +: QuoSteps+1]),
    .num_i(na_q), .den_i(den_q), .neg_i(sa_q),
    .quo_o(qa), .sat_o(sat_a), .neg_o(ng_a)
  );
  tpb_divider #(.DW(EW), .FRAC(WEIGHT_FRAC_BITS)) u_div_b (
    .clk_i, .en_i(en[DivFirst +: QuoSteps+1]),
    .num_i(nb_q), .den_i(den_q), .neg_i(sb_q),
    .quo_o(qb), .sat_o(sat_b), .neg_o(ng_b)
  );
  tpb_divider #(.DW(EW), .FRAC(WEIGHT_FRAC_BITS)) u_div_c (
    .clk_i, .en_i(en[DivFirst +: QuoSteps+1]),
    .num_i(nc_q), .den_i(den_q), .neg_i(sc_q),
    .quo_o(qc), .sat_o(sat_c), .neg_o(ng_c)
  );

  // output stage: sign, saturation, degenerate
  function automatic logic [WeightWidth-1:0] fmt(input logic [QuoSteps-1:0] q,
                                                input logic sat, input logic neg,
                                                input logic degen);
    logic [WeightWidth-1:0] r;
    priority if (degen) begin
      r = '0;
    end else if (sat) begin
      r = neg ? {1'b1, {QuoSteps{1'b0}}} : {1'b0, {QuoSteps{1'b1}}};
    end else begin
      r = neg ? WeightWidth'(-{1'b0, q}) : {1'b0, q};
    end
    return r;
  endfunction

  logic [WeightWidth-1:0] wa_out_q, wb_out_q, wc_out_q;

  always_ff @(posedge clk_i) begin
    if (en[OutSt]) begin
      wa_out_q <= fmt(qa, sat_a, ng_a, flg_q[OutSt-1].degen);
      wb_out_q <= fmt(qb, sat_b, ng_b, flg_q[OutSt-1].degen);
      wc_out_q <= fmt(qc, sat_c, ng_c, flg_q[OutSt-1].degen);
    end
  end

  assign out_valid_o  = v_q[OutSt];
  assign inside_res_o = flg_q[OutSt].in_tri;
  assign clockwise_o  = flg_q[OutSt].cw;
  assign degenerate_o = flg_q[OutSt].degen;
  assign weight_a_o   = wa_out_q;
  assign weight_b_o   = wb_out_q;
  assign weight_c_o   = wc_out_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> weight_a_o == '0 && weight_b_o == '0 &&
    weight_c_o == '0) else $error("degenerate item with nonzero weight");
  a_cw_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clockwise_o |-> inside_res_o)
    else $error("clockwise without inside");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted item lost at entry");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(weight_a_o))
    else $error("stalled result changed");
`endif

endmodule

### hdl/tpb_divider.sv
module tpb_divider #(
  parameter int unsigned DW   = 35,
  parameter int unsigned FRAC = tpb_pkg::WeightFracBitsDef
) (
  input  logic                          clk_i,
  input  logic [tpb_pkg::QuoSteps:0]    en_i,
  input  logic [DW-1:0]                 num_i,
  input  logic [DW-1:0]                 den_i,
  input  logic                          neg_i,
  output logic [tpb_pkg::QuoSteps-1:0]  quo_o,
  output logic                          sat_o,
  output logic                          neg_o
);
  import tpb_pkg::*;

  localparam int unsigned ShMax = (FRAC > QuoSteps) ? FRAC : QuoSteps;
  localparam int unsigned W     = DW + ShMax + 1;

  typedef struct packed {
    logic [W-1:0]        rem;
    logic [DW-1:0]       den;
    logic [QuoSteps-1:0] quo;
    logic                sat;
    logic                neg;
  } div_stage_t;

  div_stage_t st_q [QuoSteps+1];
  logic [W-1:0] num_sh;

  assign num_sh = W'(num_i) << FRAC;

  // first stage: saturation when quotient magnitude reaches 2^QuoSteps
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st_q[0].rem <= num_sh;
      st_q[0].den <= den_i;
      st_q[0].quo <= '0;
      st_q[0].sat <= (num_sh >= (W'(den_i) << QuoSteps));
      st_q[0].neg <= neg_i;
    end
  end

  for (genvar j = 1; j <= QuoSteps; j++) begin : g_step
    localparam int unsigned Bit = QuoSteps - j;
    logic [W-1:0] dsh;
    logic         ge;
    assign dsh = W'(st_q[j-1].den) << Bit;
    assign ge  = st_q[j-1].rem >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        st_q[j].rem <= ge ? (st_q[j-1].rem - dsh) : st_q[j-1].rem;
        st_q[j].den <= st_q[j-1].den;
        st_q[j].quo <= st_q[j-1].quo | (QuoSteps'(ge) << Bit);
        st_q[j].sat <= st_q[j-1].sat;
        st_q[j].neg <= st_q[j-1].neg;
      end
    end
  end

  assign quo_o = st_q[QuoSteps].quo;
  assign sat_o = st_q[QuoSteps].sat;
  assign neg_o = st_q[QuoSteps].neg;

endmodule

### test/tpb_checker.sv
module tpb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [tpb_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [15:0]                     point_x_i,
  input  logic [15:0]                     point_y_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            inside_res_i,
  input  logic                            clockwise_i,
  input  logic                            degenerate_i,
  input  logic [tpb_pkg::WeightWidth-1:0] weight_a_i,
  input  logic [tpb_pkg::WeightWidth-1:0] weight_b_i,
  input  logic [tpb_pkg::WeightWidth-1:0] weight_c_i,
  output int                              err_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpb_pkg::*;

  localparam int unsigned FracBits = WeightFracBitsDef;

  typedef logic [WeightWidth-1:0] weight_t;

  typedef struct packed {
    tpb_flags_t flags;
    weight_t    wa;
    weight_t    wb;
    weight_t    wc;
  } bary_t;

  bary_t expected_q[$];
  logic signed [15:0] ax, ay, bx, by, cx, cy;

  function automatic longint cross2(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    return (qx - px) * (ry - py) - (rx - px) * (qy - py);
  endfunction

  function automatic weight_t ratio(longint num, longint den);
    longint unsigned n, d, q;
    bit neg;
    if (num == 0 || den == 0) return '0;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    q = (n << FracBits) / d;
    if (neg) begin
      if (q > (64'd1 << (WeightWidth - 1))) q = 64'd1 << (WeightWidth - 1);
      return weight_t'(-q);
    end
    if (q > (64'd1 << (WeightWidth - 1)) - 1) q = (64'd1 << (WeightWidth - 1)) - 1;
    return weight_t'(q);
  endfunction

  function automatic bary_t barycentric(logic signed [15:0] px, logic signed [15:0] py);
    longint abc, pbc, pca, pab;
    bit has_neg, has_pos;
    bary_t r;
    abc = cross2(ax, ay, bx, by, cx, cy);
    pbc = cross2(px, py, bx, by, cx, cy);
    pca = cross2(px, py, cx, cy, ax, ay);
    pab = cross2(px, py, ax, ay, bx, by);
    has_neg = pbc < 0 || pca < 0 || pab < 0;
    has_pos = pbc > 0 || pca > 0 || pab > 0;
    r.flags.in_tri = !(has_neg && has_pos);
    r.flags.cw     = r.flags.in_tri && pab > 0;
    r.flags.degen  = abc == 0;
    r.wa = r.flags.degen ? '0 : ratio(pbc, abc);
    r.wb = r.flags.degen ? '0 : ratio(pca, abc);
    r.wc = r.flags.degen ? '0 : ratio(pab, abc);
    return r;
  endfunction

  task automatic cmp_field(string name, logic [WeightWidth-1:0] exp_v,
                           logic [WeightWidth-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count_o++;
    end
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bary_t e;
    if (!rst_ni) begin
      ax <= '0; ay <= '0; bx <= '0; by <= '0; cx <= '0; cy <= '0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_A_X: ax <= cfg_data_i;
          REG_A_Y: ay <= cfg_data_i;
          REG_B_X: bx <= cfg_data_i;
          REG_B_Y: by <= cfg_data_i;
          REG_C_X: cx <= cfg_data_i;
          REG_C_Y: cy <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(barycentric(point_x_i, point_y_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, actual %0h %0h %0h", $time,
                   weight_a_i, weight_b_i, weight_c_i);
          err_count_o++;
        end else begin
          e = expected_q.pop_front();
          cmp_field("inside_res", e.flags.in_tri, inside_res_i);
          cmp_field("clockwise", e.flags.cw, clockwise_i);
          cmp_field("degenerate", e.flags.degen, degenerate_i);
          cmp_field("weight_a", e.wa, weight_a_i);
          cmp_field("weight_b", e.wb, weight_b_i);
          cmp_field("weight_c", e.wc, weight_c_i);
        end
      end
    end
  end

endmodule

### test/triangle_point_barycentric_test_test.sv
module triangle_point_barycentric_test_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tpb_pkg::*;

  localparam int Latency = 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] point_x = '0;
  logic [15:0] point_y = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic inside_res, clockwise, degenerate;
  logic [WeightWidth-1:0] weight_a, weight_b, weight_c;
  int err_count, pending;
  bit sender_nogap = 0;
  int vx[3], vy[3];

  always #1 clk_i = ~clk_i;

  triangle_point_barycentric_test u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(point_x), .point_y_i(point_y),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .inside_res_o(inside_res), .clockwise_o(clockwise), .degenerate_o(degenerate),
    .weight_a_o(weight_a), .weight_b_o(weight_b), .weight_c_o(weight_c)
  );

  tpb_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .point_x_i(point_x), .point_y_i(point_y),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .inside_res_i(inside_res), .clockwise_i(clockwise), .degenerate_i(degenerate),
    .weight_a_i(weight_a), .weight_b_i(weight_b), .weight_c_i(weight_c),
    .err_count_o(err_count), .pending_o(pending)
  );

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic load_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
    drain();
    vx = '{int'(16'(x0)), int'(16'(x1)), int'(16'(x2))};
    vy = '{int'(16'(y0)), int'(16'(y1)), int'(16'(y2))};
    write_reg(REG_A_X, x0);
    write_reg(REG_A_Y, y0);
    write_reg(REG_B_X, x1);
    write_reg(REG_B_Y, y1);
    write_reg(REG_C_X, x2);
    write_reg(REG_C_Y, y2);
    // unused indexes must be ignored
    if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(6, 7)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(int x, int y);
    int gap;
    gap = sender_nogap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    point_x  <= 16'(x);
    point_y  <= 16'(y);
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic random_point();
    int sel, lox, hix, loy, hiy, k;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      lox = vx[0]; hix = vx[0]; loy = vy[0]; hiy = vy[0];
      for (k = 1; k < 3; k++) begin
        if (vx[k] < lox) lox = vx[k];
        if (vx[k] > hix) hix = vx[k];
        if (vy[k] < loy) loy = vy[k];
        if (vy[k] > hiy) hiy = vy[k];
      end
      lox = clamp16(lox - 8); hix = clamp16(hix + 8);
      loy = clamp16(loy - 8); hiy = clamp16(hiy + 8);
      send_point(rand_between(lox, hix), rand_between(loy, hiy));
    end else if (sel == 7) begin
      k = $urandom_range(0, 2);
      send_point(vx[k], vy[k]);
    end else begin
      send_point($urandom, $urandom);
    end
  endtask

  task automatic random_triangle();
    int kind, ox, oy, sz, t;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      load_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 7) begin
      sz = (kind == 4) ? 4 : (kind == 5) ? 64 : 2048;
      ox = rand_between(-30000, 30000);
      oy = rand_between(-30000, 30000);
      load_triangle(ox + rand_between(-sz, sz), oy + rand_between(-sz, sz),
                    ox + rand_between(-sz, sz), oy + rand_between(-sz, sz),
                    ox + rand_between(-sz, sz), oy + rand_between(-sz, sz));
    end else if (kind == 7) begin
      // collinear vertices
      ox = rand_between(-1000, 1000);
      oy = rand_between(-1000, 1000);
      t = rand_between(-20, 20);
      load_triangle(ox, oy, ox + 3 * t, oy + 5 * t, ox - 6 * t, oy - 10 * t);
    end else begin
      load_triangle(($urandom_range(0, 1) != 0) ? 32767 : -32768,
                    ($urandom_range(0, 1) != 0) ? 32767 : -32768,
                    ($urandom_range(0, 1) != 0) ? 32767 : -32768,
                    ($urandom_range(0, 1) != 0) ? 32767 : -32768,
                    ($urandom_range(0, 1) != 0) ? 32767 : -32768,
                    ($urandom_range(0, 1) != 0) ? 32767 : -32768);
    end
  endtask

  // result side: short random stalls, plus a long hold-off every 300 items
  initial begin
    int wait_cycles, taken;
    bit nostall;
    taken = 0;
    nostall = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 50 == 0) nostall = ($urandom_range(0, 3) == 0);
      wait_cycles = nostall ? 0 : $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      taken++;
      if (taken % 300 == 0) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk_i);
      end
    end
  end

  initial begin
    #2ms;
    $display("triangle_point_barycentric_test_test: FAIL");
    $finish;
  end

  initial begin
    int n, i;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: zero-area triangle
    vx = '{0, 0, 0};
    vy = '{0, 0, 0};
    send_point(0, 0);
    send_point(32767, -32768);

    load_triangle(0, 0, 160, 0, 0, 160);
    send_point(0, 0);
    send_point(160, 0);
    send_point(0, 160);
    send_point(53, 53);
    send_point(80, 0);
    send_point(80, 80);
    send_point(-16, -16);
    send_point(32767, 32767);
    send_point(-32768, -32768);

    load_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    send_point(-32768, 32767);
    send_point(32767, 32767);
    send_point(0, 0);
    send_point(-32768, -32768);

    // reversed winding
    load_triangle(0, 0, 0, 160, 160, 0);
    send_point(40, 40);
    send_point(200, 200);

    // tiny triangle: weights saturate far away
    load_triangle(0, 0, 1, 0, 0, 1);
    send_point(32767, 32767);
    send_point(-32768, 32767);
    send_point(1000, -1000);

    for (n = 0; n < 20; n++) begin
      random_triangle();
      for (i = 0; i < 66; i++) begin
        if (i % 22 == 0) sender_nogap = ($urandom_range(0, 2) == 0);
        random_point();
      end
    end
    sender_nogap = 0;
    drain();

    if (err_count == 0) begin
      $display("triangle_point_barycentric_test_test: PASS");
    end else begin
      $display("triangle_point_barycentric_test_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/tpb_pkg.sv
hdl/tpb_divider.sv
hdl/triangle_point_barycentric_test.sv
test/tpb_checker.sv
test/triangle_point_barycentric_test_test.sv
